>>> rtl/jss_pkg.sv
`default_nettype none
package jss_pkg;

   localparam int MAX_SCAN_BITS = 64;
   localparam int IDX_W         = $clog2(MAX_SCAN_BITS);
   localparam int LEN_W         = IDX_W + 1;

   localparam logic TMS_RAISED = 1'b1;
   localparam logic TMS_LOW    = 1'b0;
   localparam logic TDI_IDLE   = 1'b1;

   localparam logic [1:0] REQ_HARD_RESET = 2'd0;
   localparam logic [1:0] REQ_IR_SCAN    = 2'd1;
   localparam logic [1:0] REQ_DR_SCAN    = 2'd2;
   localparam logic [1:0] REQ_TICK       = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BUSY      = 2'd1;
   localparam logic [1:0] STATUS_TICK_IDLE = 2'd2;

   localparam logic [3:0] MIN_RESET_CLOCKS = 4'd5;

   localparam int          CSR_ADDR_W       = 3;
   localparam logic        CSR_SEL_RESET    = 1'b0;
   localparam logic        CSR_SEL_IDLE     = 1'b1;
   localparam logic [3:0]  RESET_CLOCKS_RST = 4'd5;
   localparam logic [3:0]  EXTRA_IDLE_RST   = 4'd2;

   typedef enum logic [12:0] {
      TAP_HARD_RST = 13'b0000000000001,
      TAP_TLR      = 13'b0000000000010,
      TAP_RTI      = 13'b0000000000100,
      TAP_SEL_DR   = 13'b0000000001000,
      TAP_CAP_DR   = 13'b0000000010000,
      TAP_SHF_DR   = 13'b0000000100000,
      TAP_EX1_DR   = 13'b0000001000000,
      TAP_UPD_DR   = 13'b0000010000000,
      TAP_SEL_IR   = 13'b0000100000000,
      TAP_CAP_IR   = 13'b0001000000000,
      TAP_SHF_IR   = 13'b0010000000000,
      TAP_EX1_IR   = 13'b0100000000000,
      TAP_UPD_IR   = 13'b1000000000000
   } tap_type;

   typedef enum logic [10:0] {
      PH_IDLE       = 11'b00000000001,
      PH_FORCE_TLR  = 11'b00000000010,
      PH_TO_RTI     = 11'b00000000100,
      PH_TO_SEL_DR  = 11'b00000001000,
      PH_TO_SEL_IR  = 11'b00000010000,
      PH_TO_CAPTURE = 11'b00000100000,
      PH_TO_SHIFT   = 11'b00001000000,
      PH_SHIFT      = 11'b00010000000,
      PH_TO_UPDATE  = 11'b00100000000,
      PH_BACK_RTI   = 11'b01000000000,
      PH_EXTRA_IDLE = 11'b10000000000
   } phase_type;

   typedef struct packed {
      tap_type                    tap;
      phase_type                  phase;
      logic                       scan_is_ir;
      logic [LEN_W-1:0]           bit_counter;
      logic [3:0]                 clock_counter;
      logic [MAX_SCAN_BITS-1:0]   out_shift;
      logic [MAX_SCAN_BITS-1:0]   in_collect;
      logic [LEN_W-1:0]           length_held;
   } seq_state_type;

   typedef struct packed {
      logic [1:0]               req_type;
      logic [MAX_SCAN_BITS-1:0] shift_out;
      logic [6:0]               scan_length;
      logic                     tdo_in;
   } req_beat_type;

   typedef struct packed {
      logic                     drive_active;
      logic                     tms;
      logic                     tdi;
      logic                     scan_done;
      logic [MAX_SCAN_BITS-1:0] captured_value;
      logic [1:0]               status;
   } rsp_beat_type;

   typedef struct packed {
      logic [3:0] reset_clocks;
      logic [3:0] extra_idle_clocks;
   } cfg_type;

endpackage
`default_nettype wire

>>> rtl/jtag_scan_sequencer.sv
`default_nettype none
// JTAG scan sequencer. Each request beat (IR scan, DR scan, port hard reset or
// TCK tick) yields exactly one response beat: TMS/TDI for the next TCK, the
// captured value when a scan ends, or no drive (port reset, idle tick). A beat
// passes an input register, then a result register; one beat per cycle is
// sustained while the response is not stalled, as the TAP step is combinational
// logic between them. Only a stalled response holds the input. The user must
// write configuration (reset_clocks at 0x0, extra_idle_clocks at 0x4) through
// the APB-style port only while idle; the block itself does not enforce this.
module jtag_scan_sequencer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [1:0]                        req_type,
   input  wire logic [jss_pkg::MAX_SCAN_BITS-1:0] req_shift_out,
   input  wire logic [6:0]                        req_scan_length,
   input  wire logic                              req_tdo_in,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_drive_active,
   output logic                                   rsp_tms,
   output logic                                   rsp_tdi,
   output logic                                   rsp_scan_done,
   output logic [jss_pkg::MAX_SCAN_BITS-1:0]      rsp_captured_value,
   output logic [1:0]                             rsp_status,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [jss_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);
   import jss_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   seq_state_type state_ff, state_in;
   seq_state_type step_nxt;
   req_beat_type  req_ff, req_in;
   logic          req_valid_ff, req_valid_in;
   rsp_beat_type  rsp_ff, rsp_in;
   rsp_beat_type  step_rsp;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_block, advance, accept, csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         if (csr_paddr[2] == CSR_SEL_IDLE) begin
            cfg_in.extra_idle_clocks = csr_pwdata[3:0];
         end else begin
            cfg_in.reset_clocks = csr_pwdata[3:0];
         end
      end
      csr_prdata = (csr_paddr[2] == CSR_SEL_RESET) ? {28'd0, cfg_ff.reset_clocks}
                                                   : {28'd0, cfg_ff.extra_idle_clocks};
   end

   jss_step u_step (
      .cur (state_ff),
      .req (req_ff),
      .cfg (cfg_ff),
      .nxt (step_nxt),
      .rsp (step_rsp)
   );

   assign out_block = rsp_valid_ff & rsp_stall;
   assign advance   = req_valid_ff & ~out_block;
   assign req_stall = req_valid_ff & out_block;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_in       = req_ff;
      if (accept) begin
         req_valid_in          = 1'b1;
         req_in.req_type       = req_type;
         req_in.shift_out      = req_shift_out;
         req_in.scan_length    = req_scan_length;
         req_in.tdo_in         = req_tdo_in;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end

      state_in     = advance ? step_nxt : state_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_in       = step_rsp;
         rsp_valid_in = 1'b1;
      end else if (!out_block) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_clocks      <= RESET_CLOCKS_RST;
         cfg_ff.extra_idle_clocks <= EXTRA_IDLE_RST;
         state_ff.tap             <= TAP_HARD_RST;
         state_ff.phase           <= PH_IDLE;
         state_ff.scan_is_ir      <= 1'b0;
         state_ff.bit_counter     <= '0;
         state_ff.clock_counter   <= '0;
         state_ff.out_shift       <= '0;
         state_ff.in_collect      <= '0;
         state_ff.length_held     <= '0;
         req_valid_ff             <= 1'b0;
         rsp_valid_ff             <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_drive_active   = rsp_ff.drive_active;
   assign rsp_tms            = rsp_ff.tms;
   assign rsp_tdi            = rsp_ff.tdi;
   assign rsp_scan_done      = rsp_ff.scan_done;
   assign rsp_captured_value = rsp_ff.captured_value;
   assign rsp_status         = rsp_ff.status;

endmodule
`default_nettype wire

>>> rtl/jss_step.sv
`default_nettype none
module jss_step (
   input  jss_pkg::seq_state_type cur,
   input  jss_pkg::req_beat_type  req,
   input  jss_pkg::cfg_type       cfg,
   output jss_pkg::seq_state_type nxt,
   output jss_pkg::rsp_beat_type  rsp
);
   import jss_pkg::*;

   function automatic logic last_bit(input seq_state_type s);
      logic [LEN_W:0] inc;
      inc = {1'b0, s.bit_counter} + {{LEN_W{1'b0}}, 1'b1};
      return inc >= {1'b0, s.length_held};
   endfunction

   function automatic rsp_beat_type pending(input seq_state_type s, input logic [1:0] st);
      rsp_beat_type r;
      r.drive_active   = 1'b1;
      r.tms            = TMS_LOW;
      r.tdi            = TDI_IDLE;
      r.scan_done      = 1'b0;
      r.captured_value = '0;
      r.status         = st;
      unique case (s.phase)
         PH_FORCE_TLR, PH_TO_SEL_DR, PH_TO_SEL_IR, PH_TO_UPDATE: begin
            r.tms = TMS_RAISED;
         end
         PH_SHIFT: begin
            r.tdi = s.out_shift[s.bit_counter[IDX_W-1:0]];
            r.tms = last_bit(s) ? TMS_RAISED : TMS_LOW;
         end
         default: begin
            r.tms = TMS_LOW;
         end
      endcase
      return r;
   endfunction

   rsp_beat_type     quiet;
   rsp_beat_type     done_beat;
   logic [3:0]       cnt_inc;
   logic [3:0]       eff_reset;
   logic [LEN_W-1:0] len;
   logic [LEN_W-1:0] bc_inc;
   logic             is_last;

   assign cnt_inc   = cur.clock_counter + 4'd1;
   assign eff_reset = (cfg.reset_clocks < MIN_RESET_CLOCKS) ? MIN_RESET_CLOCKS
                                                            : cfg.reset_clocks;
   assign bc_inc    = cur.bit_counter + {{(LEN_W-1){1'b0}}, 1'b1};
   assign is_last   = last_bit(cur);

   always_comb begin
      quiet.drive_active   = 1'b0;
      quiet.tms            = TMS_RAISED;
      quiet.tdi            = TDI_IDLE;
      quiet.scan_done      = 1'b0;
      quiet.captured_value = '0;
      quiet.status         = STATUS_OK;
      done_beat                = quiet;
      done_beat.scan_done      = 1'b1;
      done_beat.captured_value = cur.in_collect;

      if (req.scan_length == 7'd0) begin
         len = {{(LEN_W-1){1'b0}}, 1'b1};
      end else if (req.scan_length > 7'(MAX_SCAN_BITS)) begin
         len = LEN_W'(MAX_SCAN_BITS);
      end else begin
         len = LEN_W'(req.scan_length);
      end

      nxt = cur;
      rsp = quiet;

      if (req.req_type != REQ_TICK) begin
         if (cur.phase != PH_IDLE) begin
            rsp = pending(cur, STATUS_BUSY);
         end else if (req.req_type == REQ_HARD_RESET) begin
            nxt.tap = TAP_HARD_RST;
         end else begin
            nxt.length_held   = len;
            nxt.scan_is_ir    = (req.req_type == REQ_IR_SCAN);
            nxt.out_shift     = req.shift_out;
            nxt.in_collect    = '0;
            nxt.bit_counter   = '0;
            nxt.clock_counter = '0;
            if (cur.tap == TAP_RTI) begin
               nxt.phase = PH_TO_SEL_DR;
            end else if (cur.tap == TAP_TLR) begin
               nxt.phase = PH_TO_RTI;
            end else begin
               nxt.phase = PH_FORCE_TLR;
            end
            rsp = pending(nxt, STATUS_OK);
         end
      end else begin
         unique case (cur.phase)
            PH_FORCE_TLR: begin
               nxt.clock_counter = cnt_inc;
               if (cnt_inc >= eff_reset || cnt_inc == 4'd0) begin
                  nxt.tap           = TAP_TLR;
                  nxt.clock_counter = '0;
                  nxt.phase         = PH_TO_RTI;
               end
               rsp = pending(nxt, STATUS_OK);
            end
            PH_TO_RTI: begin
               nxt.tap   = TAP_RTI;
               nxt.phase = PH_TO_SEL_DR;
               rsp = pending(nxt, STATUS_OK);
            end
            PH_TO_SEL_DR: begin
               nxt.tap   = TAP_SEL_DR;
               nxt.phase = cur.scan_is_ir ? PH_TO_SEL_IR : PH_TO_CAPTURE;
               rsp = pending(nxt, STATUS_OK);
            end
            PH_TO_SEL_IR: begin
               nxt.tap   = TAP_SEL_IR;
               nxt.phase = PH_TO_CAPTURE;
               rsp = pending(nxt, STATUS_OK);
            end
            PH_TO_CAPTURE: begin
               nxt.tap   = cur.scan_is_ir ? TAP_CAP_IR : TAP_CAP_DR;
               nxt.phase = PH_TO_SHIFT;
               rsp = pending(nxt, STATUS_OK);
            end
            PH_TO_SHIFT: begin
               nxt.tap = cur.scan_is_ir ? TAP_SHF_IR : TAP_SHF_DR;
               if (cur.scan_is_ir) begin
                  nxt.in_collect = {{(MAX_SCAN_BITS-1){1'b0}}, req.tdo_in};
               end
               nxt.phase = PH_SHIFT;
               rsp = pending(nxt, STATUS_OK);
            end
            PH_SHIFT: begin
               if (cur.scan_is_ir) begin
                  if (!is_last) begin
                     nxt.in_collect[bc_inc[IDX_W-1:0]] =
                        cur.in_collect[bc_inc[IDX_W-1:0]] | req.tdo_in;
                  end
               end else begin
                  nxt.in_collect[cur.bit_counter[IDX_W-1:0]] =
                     cur.in_collect[cur.bit_counter[IDX_W-1:0]] | req.tdo_in;
               end
               if (is_last) begin
                  nxt.tap   = cur.scan_is_ir ? TAP_EX1_IR : TAP_EX1_DR;
                  nxt.phase = PH_TO_UPDATE;
               end else begin
                  nxt.bit_counter = bc_inc;
               end
               rsp = pending(nxt, STATUS_OK);
            end
            PH_TO_UPDATE: begin
               nxt.tap   = cur.scan_is_ir ? TAP_UPD_IR : TAP_UPD_DR;
               nxt.phase = PH_BACK_RTI;
               rsp = pending(nxt, STATUS_OK);
            end
            PH_BACK_RTI: begin
               nxt.tap           = TAP_RTI;
               nxt.clock_counter = '0;
               if (cfg.extra_idle_clocks == 4'd0) begin
                  nxt.phase = PH_IDLE;
                  rsp = done_beat;
               end else begin
                  nxt.phase = PH_EXTRA_IDLE;
                  rsp = pending(nxt, STATUS_OK);
               end
            end
            PH_EXTRA_IDLE: begin
               nxt.clock_counter = cnt_inc;
               if (cnt_inc >= cfg.extra_idle_clocks || cnt_inc == 4'd0) begin
                  nxt.clock_counter = '0;
                  nxt.phase         = PH_IDLE;
                  nxt.tap           = TAP_RTI;
                  rsp = done_beat;
               end else begin
                  rsp = pending(nxt, STATUS_OK);
               end
            end
            default: begin
               rsp        = quiet;
               rsp.status = STATUS_TICK_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
   import jss_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] ADDR_RESET_CLOCKS = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_EXTRA_IDLE   = 3'd4;
   localparam int                    TARGET_ITEMS      = 700;
   localparam int                    NUM_SETTINGS      = 6;

   typedef struct {
      tap_type      tap;
      phase_type    phase;
      logic         is_ir;
      logic [6:0]   bit_cnt;
      logic [3:0]   clk_cnt;
      logic [63:0]  tdi_bits;
      logic [63:0]  tdo_bits;
      logic [6:0]   len;
   } scan_ctx_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [1:0]               req_type;
   logic [MAX_SCAN_BITS-1:0] req_shift_out;
   logic [6:0]               req_scan_length;
   logic                     req_tdo_in;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_drive_active;
   logic                     rsp_tms;
   logic                     rsp_tdi;
   logic                     rsp_scan_done;
   logic [MAX_SCAN_BITS-1:0] rsp_captured_value;
   logic [1:0]               rsp_status;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_W-1:0]    csr_paddr;
   logic [31:0]              csr_pwdata;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   jtag_scan_sequencer u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_shift_out      (req_shift_out),
      .req_scan_length    (req_scan_length),
      .req_tdo_in         (req_tdo_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_drive_active   (rsp_drive_active),
      .rsp_tms            (rsp_tms),
      .rsp_tdi            (rsp_tdi),
      .rsp_scan_done      (rsp_scan_done),
      .rsp_captured_value (rsp_captured_value),
      .rsp_status         (rsp_status),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   // checker copy of the sequencer and a planning copy used by the generator
   scan_ctx_type tap_model;
   cfg_type      tap_cfg;
   scan_ctx_type plan;
   cfg_type      plan_cfg;

   req_beat_type pending_beats[$];
   rsp_beat_type expected_beats[$];
   req_beat_type taken_beat;
   rsp_beat_type want_beat;
   req_beat_type drive_beat;

   int           items_queued;
   int           items_taken;
   int           items_sent;
   int           mismatches;
   int           n_scans;
   int           n_port_resets;
   int           n_busy;
   int           n_idle_ticks;
   int           n_beats;
   int           n_settings;
   int unsigned  send_gap;
   int unsigned  stall_left;
   logic         req_fire;
   logic [31:0]  cycle_count;
   logic         calm;

   assign calm = (cycle_count[8:0] < 9'd80);

   function automatic scan_ctx_type ctx_after_reset();
      scan_ctx_type s;
      s.tap      = TAP_HARD_RST;
      s.phase    = PH_IDLE;
      s.is_ir    = 1'b0;
      s.bit_cnt  = '0;
      s.clk_cnt  = '0;
      s.tdi_bits = '0;
      s.tdo_bits = '0;
      s.len      = '0;
      return s;
   endfunction

   function automatic rsp_beat_type quiet_beat(logic done, logic [63:0] cap, logic [1:0] st);
      rsp_beat_type o;
      o.drive_active   = 1'b0;
      o.tms            = TMS_RAISED;
      o.tdi            = TDI_IDLE;
      o.scan_done      = done;
      o.captured_value = cap;
      o.status         = st;
      return o;
   endfunction

   function automatic rsp_beat_type clock_beat(scan_ctx_type s, logic [1:0] st);
      rsp_beat_type o;
      o.drive_active   = 1'b1;
      o.tms            = TMS_LOW;
      o.tdi            = TDI_IDLE;
      o.scan_done      = 1'b0;
      o.captured_value = '0;
      o.status         = st;
      case (s.phase)
         PH_FORCE_TLR, PH_TO_SEL_DR, PH_TO_SEL_IR, PH_TO_UPDATE: o.tms = TMS_RAISED;
         PH_SHIFT: begin
            o.tdi = s.tdi_bits[s.bit_cnt[5:0]];
            o.tms = (int'(s.bit_cnt) + 1 >= int'(s.len)) ? TMS_RAISED : TMS_LOW;
         end
         default: ;
      endcase
      return o;
   endfunction

   // advance the sequencer by one beat and return the result it gives
   function automatic rsp_beat_type jtag_step(inout scan_ctx_type s, input cfg_type c,
                                              input req_beat_type r);
      logic [6:0] n;
      logic [3:0] rc_eff;
      logic       last;
      logic       done;
      rc_eff = (c.reset_clocks < MIN_RESET_CLOCKS) ? MIN_RESET_CLOCKS : c.reset_clocks;
      last   = (int'(s.bit_cnt) + 1 >= int'(s.len));
      done   = 1'b0;
      if (r.req_type != REQ_TICK) begin
         if (s.phase != PH_IDLE)
            return clock_beat(s, STATUS_BUSY);
         if (r.req_type == REQ_HARD_RESET) begin
            s.tap = TAP_HARD_RST;
            return quiet_beat(1'b0, '0, STATUS_OK);
         end
         n = r.scan_length;
         if (n == 7'd0)
            n = 7'd1;
         else if (n > 7'(MAX_SCAN_BITS))
            n = 7'(MAX_SCAN_BITS);
         s.len      = n;
         s.is_ir    = (r.req_type == REQ_IR_SCAN);
         s.tdi_bits = r.shift_out;
         s.tdo_bits = '0;
         s.bit_cnt  = '0;
         s.clk_cnt  = '0;
         if (s.tap == TAP_RTI)
            s.phase = PH_TO_SEL_DR;
         else if (s.tap == TAP_TLR)
            s.phase = PH_TO_RTI;
         else
            s.phase = PH_FORCE_TLR;
         return clock_beat(s, STATUS_OK);
      end
      case (s.phase)
         PH_FORCE_TLR: begin
            s.clk_cnt = s.clk_cnt + 4'd1;
            if (s.clk_cnt >= rc_eff || s.clk_cnt == 4'd0) begin
               s.tap     = TAP_TLR;
               s.clk_cnt = '0;
               s.phase   = PH_TO_RTI;
            end
         end
         PH_TO_RTI: begin
            s.tap   = TAP_RTI;
            s.phase = PH_TO_SEL_DR;
         end
         PH_TO_SEL_DR: begin
            s.tap = TAP_SEL_DR;
            if (s.is_ir)
               s.phase = PH_TO_SEL_IR;
            else
               s.phase = PH_TO_CAPTURE;
         end
         PH_TO_SEL_IR: begin
            s.tap   = TAP_SEL_IR;
            s.phase = PH_TO_CAPTURE;
         end
         PH_TO_CAPTURE: begin
            if (s.is_ir)
               s.tap = TAP_CAP_IR;
            else
               s.tap = TAP_CAP_DR;
            s.phase = PH_TO_SHIFT;
         end
         PH_TO_SHIFT: begin
            if (s.is_ir) begin
               s.tap      = TAP_SHF_IR;
               s.tdo_bits = {63'd0, r.tdo_in};
            end else begin
               s.tap = TAP_SHF_DR;
            end
            s.phase = PH_SHIFT;
         end
         PH_SHIFT: begin
            // IR capture runs one bit ahead: the last shift bit is dropped
            if (s.is_ir) begin
               if (!last)
                  s.tdo_bits[s.bit_cnt[5:0] + 6'd1] = r.tdo_in;
            end else begin
               s.tdo_bits[s.bit_cnt[5:0]] = r.tdo_in;
            end
            if (last) begin
               if (s.is_ir)
                  s.tap = TAP_EX1_IR;
               else
                  s.tap = TAP_EX1_DR;
               s.phase = PH_TO_UPDATE;
            end else begin
               s.bit_cnt = s.bit_cnt + 7'd1;
            end
         end
         PH_TO_UPDATE: begin
            if (s.is_ir)
               s.tap = TAP_UPD_IR;
            else
               s.tap = TAP_UPD_DR;
            s.phase = PH_BACK_RTI;
         end
         PH_BACK_RTI: begin
            s.tap     = TAP_RTI;
            s.clk_cnt = '0;
            if (c.extra_idle_clocks == 4'd0)
               done = 1'b1;
            else
               s.phase = PH_EXTRA_IDLE;
         end
         PH_EXTRA_IDLE: begin
            s.clk_cnt = s.clk_cnt + 4'd1;
            if (s.clk_cnt >= c.extra_idle_clocks || s.clk_cnt == 4'd0) begin
               s.clk_cnt = '0;
               done      = 1'b1;
            end
         end
         default: return quiet_beat(1'b0, '0, STATUS_TICK_IDLE);
      endcase
      if (done) begin
         s.phase = PH_IDLE;
         s.tap   = TAP_RTI;
         return quiet_beat(1'b1, s.tdo_bits, STATUS_OK);
      end
      return clock_beat(s, STATUS_OK);
   endfunction

   function automatic int unsigned pause_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [63:0] rand64();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return '0;
      if (r == 1)
         return '1;
      return {$urandom, $urandom};
   endfunction

   function automatic logic [6:0] pick_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 7'($urandom_range(1, 12));
      if (r < 90)
         return 7'($urandom_range(13, 64));
      return 7'($urandom_range(0, 127));
   endfunction

   task automatic queue_beat(logic [1:0] kind, logic [63:0] data, logic [6:0] len,
                             logic tdo, output rsp_beat_type p);
      req_beat_type r;
      r.req_type    = kind;
      r.shift_out   = data;
      r.scan_length = len;
      r.tdo_in      = tdo;
      p = jtag_step(plan, plan_cfg, r);
      pending_beats.push_back(r);
      items_queued++;
      if (p.status != STATUS_BUSY)
         items_sent++;
   endtask

   task automatic queue_tick(output rsp_beat_type p);
      queue_beat(REQ_TICK, rand64(), 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)), p);
   endtask

   // one scan request followed by ticks until it completes, optionally with busy requests mixed in
   task automatic run_scan(logic [1:0] kind, logic [6:0] len, logic [63:0] data,
                           logic busy_first, int unsigned noise_pct);
      rsp_beat_type p;
      queue_beat(kind, data, len, 1'($urandom_range(0, 1)), p);
      if (busy_first) begin
         queue_beat(REQ_HARD_RESET, rand64(), pick_len(), 1'b0, p);
         queue_beat(REQ_IR_SCAN, rand64(), pick_len(), 1'b1, p);
         queue_beat(REQ_DR_SCAN, rand64(), pick_len(), 1'b0, p);
      end
      do begin
         if ($urandom_range(0, 99) < noise_pct)
            queue_beat(2'($urandom_range(0, 2)), rand64(), 7'($urandom_range(0, 127)),
                       1'($urandom_range(0, 1)), p);
         queue_tick(p);
      end while (!p.scan_done);
   endtask

   task automatic drain();
      while (items_queued != items_taken || expected_beats.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [3:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = {28'($urandom), value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      if (addr == ADDR_RESET_CLOCKS)
         plan_cfg.reset_clocks = value;
      else
         plan_cfg.extra_idle_clocks = value;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // drive request beats, hold while stalled
   always @(negedge clock) begin
      if (!req_valid || req_fire) begin
         if (send_gap != 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_beats.size() != 0) begin
            drive_beat = pending_beats.pop_front();
            req_valid       <= 1'b1;
            req_type        <= drive_beat.req_type;
            req_shift_out   <= drive_beat.shift_out;
            req_scan_length <= drive_beat.scan_length;
            req_tdo_in      <= drive_beat.tdo_in;
            if (!calm)
               send_gap = pause_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (!calm)
            stall_left = pause_len();
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 32'd1;
      req_fire    <= req_valid && !req_stall && !reset;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            taken_beat.req_type    = req_type;
            taken_beat.shift_out   = req_shift_out;
            taken_beat.scan_length = req_scan_length;
            taken_beat.tdo_in      = req_tdo_in;
            expected_beats.push_back(jtag_step(tap_model, tap_cfg, taken_beat));
            items_taken++;
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == ADDR_RESET_CLOCKS)
               tap_cfg.reset_clocks = csr_pwdata[3:0];
            else if (csr_paddr == ADDR_EXTRA_IDLE)
               tap_cfg.extra_idle_clocks = csr_pwdata[3:0];
         end
         if (rsp_valid && !rsp_stall) begin
            n_beats++;
            if (expected_beats.size() == 0) begin
               $error("result beat with nothing expected");
               mismatches++;
            end else begin
               want_beat = expected_beats.pop_front();
               if (rsp_drive_active !== want_beat.drive_active) begin
                  $error("drive_active: expected %0b, got %0b",
                         want_beat.drive_active, rsp_drive_active);
                  mismatches++;
               end
               if (rsp_tms !== want_beat.tms) begin
                  $error("tms: expected %0b, got %0b", want_beat.tms, rsp_tms);
                  mismatches++;
               end
               if (rsp_tdi !== want_beat.tdi) begin
                  $error("tdi: expected %0b, got %0b", want_beat.tdi, rsp_tdi);
                  mismatches++;
               end
               if (rsp_scan_done !== want_beat.scan_done) begin
                  $error("scan_done: expected %0b, got %0b", want_beat.scan_done, rsp_scan_done);
                  mismatches++;
               end
               if (rsp_captured_value !== want_beat.captured_value) begin
                  $error("captured_value: expected %h, got %h",
                         want_beat.captured_value, rsp_captured_value);
                  mismatches++;
               end
               if (rsp_status !== want_beat.status) begin
                  $error("status: expected %0d, got %0d", want_beat.status, rsp_status);
                  mismatches++;
               end
               if (want_beat.scan_done)
                  n_scans++;
               if (want_beat.status == STATUS_BUSY)
                  n_busy++;
               if (want_beat.status == STATUS_TICK_IDLE)
                  n_idle_ticks++;
               if (!want_beat.drive_active && !want_beat.scan_done &&
                   want_beat.status == STATUS_OK)
                  n_port_resets++;
            end
         end
      end
   end

   initial begin
      rsp_beat_type p;
      cfg_type      settings [NUM_SETTINGS];
      int           k;
      int           quota;
      int unsigned  r;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_type        = REQ_TICK;
      req_shift_out   = '0;
      req_scan_length = '0;
      req_tdo_in      = 1'b0;
      rsp_stall       = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      req_fire        = 1'b0;
      cycle_count     = '0;
      send_gap        = 0;
      stall_left      = 0;
      items_queued    = 0;
      items_taken     = 0;
      items_sent      = 0;
      mismatches      = 0;
      n_scans         = 0;
      n_port_resets   = 0;
      n_busy          = 0;
      n_idle_ticks    = 0;
      n_beats         = 0;
      n_settings      = 1;
      tap_model       = ctx_after_reset();
      plan            = ctx_after_reset();
      tap_cfg.reset_clocks      = RESET_CLOCKS_RST;
      tap_cfg.extra_idle_clocks = EXTRA_IDLE_RST;
      plan_cfg        = tap_cfg;

      settings[0] = '{reset_clocks: 4'd15, extra_idle_clocks: 4'd0};
      settings[1] = '{reset_clocks: 4'd0,  extra_idle_clocks: 4'd15};
      settings[2] = '{reset_clocks: 4'd4,  extra_idle_clocks: 4'd1};
      settings[3] = '{reset_clocks: 4'd5,  extra_idle_clocks: 4'd7};
      settings[4] = '{reset_clocks: 4'($urandom), extra_idle_clocks: 4'($urandom)};
      settings[5] = '{reset_clocks: 4'($urandom), extra_idle_clocks: 4'($urandom)};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: idle tick, port reset, shortest scans, the first with busy requests
      queue_tick(p);
      queue_beat(REQ_HARD_RESET, '1, 7'd127, 1'b1, p);
      run_scan(REQ_IR_SCAN, 7'd0, '1, 1'b1, 0);
      run_scan(REQ_DR_SCAN, 7'd1, '0, 1'b0, 0);

      for (k = 0; k < NUM_SETTINGS; k++) begin
         drain();
         csr_write(ADDR_RESET_CLOCKS, settings[k].reset_clocks);
         csr_write(ADDR_EXTRA_IDLE, settings[k].extra_idle_clocks);
         n_settings++;
         queue_beat(REQ_HARD_RESET, rand64(), pick_len(), 1'b0, p);
         if (k == 0) begin
            run_scan(REQ_DR_SCAN, 7'd64, rand64(), 1'b0, 5);
            run_scan(REQ_IR_SCAN, 7'd127, rand64(), 1'b0, 5);
         end
         quota = (TARGET_ITEMS * (k + 1)) / NUM_SETTINGS;
         while (items_sent < quota) begin
            if (k == 2 && items_sent > quota - 40 && items_sent < quota - 20)
               drain();
            r = $urandom_range(0, 99);
            if (r < 25)
               queue_beat(REQ_HARD_RESET, rand64(), pick_len(), 1'($urandom_range(0, 1)), p);
            else if (r < 33)
               repeat ($urandom_range(1, 3)) queue_tick(p);
            run_scan($urandom_range(0, 1) ? REQ_IR_SCAN : REQ_DR_SCAN, pick_len(), rand64(),
                     $urandom_range(0, 9) == 0, 5);
         end
      end

      drain();
      repeat (8) @(negedge clock);
      if (expected_beats.size() != 0) begin
         $error("%0d expected result beats never arrived", expected_beats.size());
         mismatches++;
      end
      $display("Covered %0d IR/DR scans and %0d port resets over %0d register settings.",
               n_scans, n_port_resets, n_settings);
      $display("Checked %0d result beats, %0d busy rejections, %0d idle ticks.",
               n_beats, n_busy, n_idle_ticks);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
